// ===== rtl/mwe_pkg.sv =====
// ----------------------------------------------------------------------------
// mwe_pkg: shared types and constants for the three-wire serial EEPROM core
// Phase codes, opcode and register indexes, and the geometry decode per kind.
// ----------------------------------------------------------------------------
package mwe_pkg;

	// Store depth in words; index bits derived from it (power of two assumed).
	localparam int STORE_WORDS = 1024;
	localparam int STORE_AW    = $clog2(STORE_WORDS);
	localparam int WORD_W      = 16;
	localparam int ADDR_W      = 11;
	localparam int CMD_W       = 17;

	localparam logic [15:0] ALL_ONES = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_DATA,
		PH_BUSY,
		PH_WAIT
	} phase_t;

	// item kinds
	localparam logic [1:0] FN_STROBE = 2'd0;
	localparam logic [1:0] FN_LATCH  = 2'd1;
	localparam logic [1:0] FN_POLL   = 2'd2;

	// configuration register indexes
	localparam logic REG_CHIP_KIND   = 1'b0;
	localparam logic REG_BYTE_ACCESS = 1'b1;

	// chip kinds
	localparam logic [2:0] KIND_C46 = 3'd1;
	localparam logic [2:0] KIND_C56 = 3'd2;
	localparam logic [2:0] KIND_C66 = 3'd3;
	localparam logic [2:0] KIND_C76 = 3'd4;
	localparam logic [2:0] KIND_C86 = 3'd5;

	// opcodes and the enable/disable sub-opcodes
	localparam logic [1:0] OP_EXT   = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_ERASE = 2'd3;
	localparam logic [1:0] SUB_EWDS = 2'd0;
	localparam logic [1:0] SUB_EWEN = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] mask;
		logic [3:0]        cmd_len;
		logic [3:0]        addr_len;
		logic              byte_mode;
		logic              real_chip;
	} geom_t;

	function automatic geom_t geom_decode(input logic [2:0] kind, input logic byte_acc);
		geom_t g;
		g.real_chip = 1'b1;
		g.byte_mode = byte_acc;
		unique case (kind)
			KIND_C46: begin g.mask = 11'h07F; g.cmd_len = 4'd10; g.addr_len = 4'd7;  end
			KIND_C56: begin g.mask = 11'h0FF; g.cmd_len = 4'd12; g.addr_len = 4'd9;  end
			KIND_C66: begin g.mask = 11'h1FF; g.cmd_len = 4'd12; g.addr_len = 4'd9;  end
			KIND_C76: begin g.mask = 11'h3FF; g.cmd_len = 4'd14; g.addr_len = 4'd11; end
			KIND_C86: begin g.mask = 11'h7FF; g.cmd_len = 4'd14; g.addr_len = 4'd11; end
			default: begin
				g.mask     = '0;
				g.cmd_len  = 4'd1;
				g.addr_len = 4'd1;
				g.real_chip = 1'b0;
			end
		endcase
		if (!byte_acc) begin
			g.mask     = g.mask >> 1;
			g.cmd_len  = g.cmd_len - 4'd1;
			g.addr_len = g.addr_len - 4'd1;
		end
		return g;
	endfunction

endpackage

// ===== rtl/mwe_ram.sv =====
// ----------------------------------------------------------------------------
// mwe_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mwe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/microwire_eeprom_93cx6_core.sv =====
// ----------------------------------------------------------------------------
// microwire_eeprom_93cx6_core: three-wire serial EEPROM, 93C46..93C86
// Port events in, one DO level out per item; word store kept in a RAM.
// ----------------------------------------------------------------------------
//
//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------------------
//  input     | in_valid / in_ready | func, count_value, io_direction, io_level
//  output    | out_valid/out_ready | data_out
//  config    | cfg_we (no wait)    | cfg_index, cfg_data
//
//  One item per cycle while in_ready is high. Each item updates the control
//  registers at once and issues at most one RAM access; a READ word comes from
//  the RAM's registered read port into read_shift, and a write merges with the
//  old word in the access stage (read-modify-write). After reset a clearing
//  pass fills all STORE_WORDS (1024) words with ones, with in_ready low. Results
//  go through a two-entry output queue, so input keeps flowing while one result
//  waits; once clear, in_ready drops only when both entries are full.
//
module microwire_eeprom_93cx6_core (
	input  logic       clk,
	input  logic       arst_n,
	// input items
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] count_value,
	input  logic [7:0] io_direction,
	input  logic [7:0] io_level,
	// result items
	output logic       out_valid,
	input  logic       out_ready,
	output logic       data_out,
	// configuration
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [2:0] cfg_data
);

	localparam int AW = mwe_pkg::STORE_AW;

	// configuration
	logic [2:0] chip_kind_q;
	logic       byte_access_q;
	mwe_pkg::geom_t geom;

	// control state
	mwe_pkg::phase_t phase_q, phase_n;
	logic [1:0]  busy_ticks_q, busy_ticks_n;
	logic [15:0] read_shift_q, read_shift_n;
	logic [mwe_pkg::CMD_W-1:0]  cmd_shift_q, cmd_shift_n;
	logic [mwe_pkg::ADDR_W-1:0] word_addr_q, word_addr_n;
	logic [3:0]  bits_left_q, bits_left_n;
	logic        write_locked_q, write_locked_n;
	logic        last_clock_q, last_clock_n;
	logic [7:0]  dir_latch_q, dir_latch_n;
	logic [7:0]  level_latch_q, level_latch_n;
	logic        out_level_q, out_level_n;

	// RAM access requested by this item
	logic                       acc_rd, acc_wr;
	logic [mwe_pkg::ADDR_W-1:0] acc_addr;
	logic [15:0]                acc_wdata;

	// access stage, registered behind the item
	logic          rd_s1, wr_s1, byte_s1, lane_s1;
	logic [AW-1:0] idx_s1;
	logic [15:0]   wdata_s1;

	// clearing pass
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr, acc_idx;
	logic [15:0]   ram_wdata, ram_rdata;

	// output queue
	logic [1:0] cnt_q;
	logic       q0_q, q1_q;
	logic       in_fire, out_fire;

	assign geom     = mwe_pkg::geom_decode(chip_kind_q, byte_access_q);
	assign in_ready = !clr_q && (cnt_q != 2'd2);
	assign in_fire  = in_valid && in_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_fire  = out_valid && out_ready;
	assign data_out  = q0_q;

	// ------------------------------------------------------------------
	// Per-item next state
	// ------------------------------------------------------------------
	always_comb begin
		logic                      clk_bit, cs_bit, rise, driven, di;
		logic [mwe_pkg::CMD_W-1:0] sh, op_word, sub_word;
		logic [3:0]                bl_dec;
		logic                      done_hit;

		phase_n        = phase_q;
		busy_ticks_n   = busy_ticks_q;
		read_shift_n   = read_shift_q;
		cmd_shift_n    = cmd_shift_q;
		word_addr_n    = word_addr_q;
		bits_left_n    = bits_left_q;
		write_locked_n = write_locked_q;
		last_clock_n   = last_clock_q;
		dir_latch_n    = dir_latch_q;
		level_latch_n  = level_latch_q;
		out_level_n    = out_level_q;
		acc_rd         = 1'b0;
		acc_wr         = 1'b0;
		acc_addr       = word_addr_q;
		acc_wdata      = cmd_shift_q[15:0];

		clk_bit  = count_value[1];
		cs_bit   = count_value[7];
		rise     = clk_bit && !last_clock_q;
		driven   = dir_latch_q[4];
		di       = driven && level_latch_q[4];
		sh       = {cmd_shift_q[mwe_pkg::CMD_W-2:0], di};
		bl_dec   = bits_left_q - 4'd1;
		op_word  = sh >> geom.addr_len;
		sub_word = sh >> (geom.addr_len - 4'd2);
		done_hit = geom.byte_mode ? sh[8] : sh[16];

		case (func)
			mwe_pkg::FN_STROBE: begin
				last_clock_n = clk_bit;
				if (rise) begin
					// shift one read bit out first
					out_level_n  = geom.byte_mode ? read_shift_q[7] : read_shift_q[15];
					read_shift_n = {read_shift_q[14:0], 1'b0};
					unique case (cs_bit ? phase_q : mwe_pkg::PH_IDLE)
						mwe_pkg::PH_IDLE: begin
							phase_n     = mwe_pkg::PH_IDLE;
							cmd_shift_n = '0;
							if (cs_bit) begin
								if (di) begin
									out_level_n = 1'b0;
									phase_n     = mwe_pkg::PH_START;
									bits_left_n = geom.cmd_len - 4'd1;
								end else if (!driven) begin
									phase_n      = mwe_pkg::PH_BUSY;
									read_shift_n = '0;
									out_level_n  = 1'b0;
									busy_ticks_n = '0;
								end
							end
						end
						mwe_pkg::PH_START: begin
							cmd_shift_n = sh;
							bits_left_n = bl_dec;
							if (bl_dec == 4'd0 && geom.real_chip) begin
								// full command collected
								phase_n     = mwe_pkg::PH_IDLE;
								word_addr_n = sh[mwe_pkg::ADDR_W-1:0] & geom.mask;
								acc_addr    = word_addr_n;
								if (op_word[mwe_pkg::CMD_W-1:2] == '0) begin
									case (op_word[1:0])
										mwe_pkg::OP_ERASE: begin
											acc_wr    = !write_locked_q;
											acc_wdata = mwe_pkg::ALL_ONES;
										end
										mwe_pkg::OP_READ: begin
											acc_rd      = 1'b1;
											out_level_n = 1'b0;
											phase_n     = mwe_pkg::PH_WAIT;
										end
										mwe_pkg::OP_WRITE: begin
											// marker bit tells when the data is in
											cmd_shift_n = mwe_pkg::CMD_W'(1);
											phase_n     = mwe_pkg::PH_DATA;
										end
										default: begin
											if (sub_word[1:0] == mwe_pkg::SUB_EWDS) begin
												write_locked_n = 1'b1;
											end else if (sub_word[1:0] == mwe_pkg::SUB_EWEN) begin
												write_locked_n = 1'b0;
											end
										end
									endcase
								end
							end
						end
						mwe_pkg::PH_DATA: begin
							cmd_shift_n = sh;
							if (done_hit) begin
								acc_wr       = !write_locked_q;
								acc_wdata    = sh[15:0];
								busy_ticks_n = '0;
								read_shift_n = '0;
								out_level_n  = 1'b0;
								phase_n      = mwe_pkg::PH_WAIT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			mwe_pkg::FN_LATCH: begin
				dir_latch_n   = io_direction;
				level_latch_n = io_level;
			end
			mwe_pkg::FN_POLL: begin
				if (phase_q == mwe_pkg::PH_BUSY || phase_q == mwe_pkg::PH_IDLE) begin
					if (busy_ticks_q < 2'd2) begin
						busy_ticks_n = busy_ticks_q + 2'd1;
						read_shift_n = '0;
						out_level_n  = 1'b0;
					end else begin
						read_shift_n = mwe_pkg::ALL_ONES;
						out_level_n  = 1'b1;
						phase_n      = mwe_pkg::PH_WAIT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// word index: byte mode drops the lane bit; wraps at the store depth
	always_comb begin
		logic [mwe_pkg::ADDR_W-1:0] widx;
		widx    = geom.byte_mode ? (acc_addr >> 1) : acc_addr;
		acc_idx = widx[AW-1:0];
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_kind_q   <= '0;
			byte_access_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mwe_pkg::REG_CHIP_KIND:   chip_kind_q   <= cfg_data;
				mwe_pkg::REG_BYTE_ACCESS: byte_access_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= mwe_pkg::PH_IDLE;
			busy_ticks_q   <= '0;
			read_shift_q   <= '0;
			cmd_shift_q    <= '0;
			word_addr_q    <= '0;
			bits_left_q    <= '0;
			write_locked_q <= 1'b1;
			last_clock_q   <= 1'b0;
			dir_latch_q    <= '0;
			level_latch_q  <= '0;
			out_level_q    <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q        <= phase_n;
				busy_ticks_q   <= busy_ticks_n;
				cmd_shift_q    <= cmd_shift_n;
				word_addr_q    <= word_addr_n;
				bits_left_q    <= bits_left_n;
				write_locked_q <= write_locked_n;
				last_clock_q   <= last_clock_n;
				dir_latch_q    <= dir_latch_n;
				level_latch_q  <= level_latch_n;
				out_level_q    <= out_level_n;
			end
			// READ word arrives; no item in this cycle can touch read_shift
			// (phase is WAIT and a rising clock needs a low strobe first)
			if (rd_s1) begin
				if (byte_s1) begin
					read_shift_q <= {8'h00, lane_s1 ? ram_rdata[15:8] : ram_rdata[7:0]};
				end else begin
					read_shift_q <= ram_rdata;
				end
			end else if (in_fire) begin
				read_shift_q <= read_shift_n;
			end
		end
	end

	// access stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			wr_s1 <= 1'b0;
		end else begin
			rd_s1 <= in_fire && acc_rd;
			wr_s1 <= in_fire && acc_wr;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= acc_idx;
		lane_s1  <= acc_addr[0];
		byte_s1  <= geom.byte_mode;
		wdata_s1 <= acc_wdata;
	end

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(mwe_pkg::STORE_WORDS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// RAM: rising edges are at least two items apart, so a write-back never
	// meets another access to the store in the same cycle
	always_comb begin
		ram_raddr = acc_idx;
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = mwe_pkg::ALL_ONES;
		end else begin
			ram_we    = wr_s1;
			ram_waddr = idx_s1;
			if (!byte_s1) begin
				ram_wdata = wdata_s1;
			end else if (lane_s1) begin
				ram_wdata = {wdata_s1[7:0], ram_rdata[7:0]};
			end else begin
				ram_wdata = {ram_rdata[15:8], wdata_s1[7:0]};
			end
		end
	end

	mwe_ram #(
		.WIDTH(mwe_pkg::WORD_W),
		.DEPTH(mwe_pkg::STORE_WORDS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// two-entry output queue, head in q0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({in_fire, out_fire})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({in_fire, out_fire})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					q0_q <= out_level_n;
				end else begin
					q1_q <= out_level_n;
				end
			end
			2'b01: q0_q <= q1_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					q0_q <= out_level_n;
				end else begin
					q0_q <= q1_q;
					q1_q <= out_level_n;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/mwe_checker.sv =====
// ----------------------------------------------------------------------------
// mwe_checker: port-level checks for the serial EEPROM core
// Clearing after reset, one result per item, held output while stalled.
// ----------------------------------------------------------------------------
module mwe_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic data_out
);

	// store is being cleared right after reset
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready)
		else $error("input taken during clearing pass");

	// every accepted item yields a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

	// no result without an item
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready) |=> !out_valid)
		else $error("result appeared without an item");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out))
		else $error("stalled result dropped or changed");

endmodule

bind microwire_eeprom_93cx6_core mwe_checker u_mwe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.data_out (data_out)
);

// ===== tb/tb_microwire_eeprom_93cx6_core.sv =====
// ----------------------------------------------------------------------------
// tb_microwire_eeprom_93cx6_core: self-checking bench for the serial EEPROM core
// Drives port events as bit-banged three-wire transactions across all chip
// kinds and both organizations, predicts every DO level and checks each result.
// ----------------------------------------------------------------------------
module tb_microwire_eeprom_93cx6_core;

	// unused item kind and the kinds with no chip behind them
	localparam logic [1:0] FN_SPARE    = 2'd3;
	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;
	// sub-opcodes that the core accepts and ignores
	localparam logic [1:0] SUB_WRAL    = 2'd1;
	localparam logic [1:0] SUB_ERAL    = 2'd2;

	localparam int QUIET_LIMIT  = 4000; // cycles with no item moving; covers the clear pass
	localparam int HOLD_CYCLES  = 150;  // long receiver hold-off
	localparam int SETTLE       = 8;    // lets a trailing RAM merge finish
	localparam int PHASE_ITEMS  = 12;
	localparam int NUM_SETTINGS = 13;

	// per-phase settings, entry 0 on the right
	localparam logic [NUM_SETTINGS-1:0][2:0] KIND_SEQ = {
		mwe_pkg::KIND_C76, mwe_pkg::KIND_C66, KIND_SPARE6, mwe_pkg::KIND_C56,
		KIND_SPARE7, mwe_pkg::KIND_C76, mwe_pkg::KIND_C66, mwe_pkg::KIND_C56,
		KIND_NONE, mwe_pkg::KIND_C86, mwe_pkg::KIND_C86, mwe_pkg::KIND_C46,
		mwe_pkg::KIND_C46};
	localparam logic [NUM_SETTINGS-1:0] BYTE_SEQ = 13'b0100110100101;

	typedef enum int {CMD_FULL, CMD_CUT_DROP, CMD_CUT_HOLD} cmd_shape_t;

	// Tracks the EEPROM state and the DO levels still owed by the core.
	class do_scoreboard;
		logic [2:0]  kind;
		logic        byte_acc;
		logic [10:0] word_mask;
		int          cmd_len;
		int          addr_len;
		logic [16:0] done_bit;
		bit          real_chip;

		mwe_pkg::phase_t phase;
		logic [1:0]  busy_ticks;
		logic [15:0] read_shift;
		logic [16:0] cmd_shift;
		logic [10:0] word_addr;
		logic [3:0]  bits_left;
		logic        locked;
		logic        last_clk;
		logic [7:0]  dir_latch;
		logic [7:0]  level_latch;
		logic        out_level;
		logic [15:0] cells [mwe_pkg::STORE_WORDS];

		logic        do_levels_due [$];
		int          errors;
		int          checked;

		function new();
			kind       = KIND_NONE;
			byte_acc   = 1'b0;
			phase      = mwe_pkg::PH_IDLE;
			busy_ticks = '0;
			read_shift = '0;
			cmd_shift  = '0;
			word_addr  = '0;
			bits_left  = '0;
			locked     = 1'b1;
			last_clk   = 1'b0;
			dir_latch  = '0;
			level_latch = '0;
			out_level  = 1'b0;
			errors     = 0;
			checked    = 0;
			foreach (cells[i]) cells[i] = mwe_pkg::ALL_ONES;
			derive();
		endfunction

		// geometry of the selected part
		function void derive();
			real_chip = 1'b1;
			case (kind)
				mwe_pkg::KIND_C46: begin word_mask = 11'h07F; cmd_len = 10; addr_len = 7;  end
				mwe_pkg::KIND_C56: begin word_mask = 11'h0FF; cmd_len = 12; addr_len = 9;  end
				mwe_pkg::KIND_C66: begin word_mask = 11'h1FF; cmd_len = 12; addr_len = 9;  end
				mwe_pkg::KIND_C76: begin word_mask = 11'h3FF; cmd_len = 14; addr_len = 11; end
				mwe_pkg::KIND_C86: begin word_mask = 11'h7FF; cmd_len = 14; addr_len = 11; end
				default: begin
					word_mask = '0;
					cmd_len   = 1;
					addr_len  = 1;
					real_chip = 1'b0;
				end
			endcase
			if (byte_acc) begin
				done_bit = 17'h00100;
			end else begin
				word_mask = word_mask >> 1;
				cmd_len   = cmd_len - 1;
				addr_len  = addr_len - 1;
				done_bit  = 17'h10000;
			end
		endfunction

		function void set_reg(logic idx, logic [2:0] val);
			if (idx == mwe_pkg::REG_CHIP_KIND) kind = val;
			else byte_acc = val[0];
			derive();
		endfunction

		function logic [15:0] fetch(logic [10:0] a);
			logic [15:0] w;
			if (byte_acc) begin
				w = cells[a[10:1]];
				return a[0] ? {8'h00, w[15:8]} : {8'h00, w[7:0]};
			end
			return cells[a[9:0]];
		endfunction

		function void commit(logic [10:0] a, logic [16:0] v);
			if (!byte_acc) cells[a[9:0]] = v[15:0];
			else if (a[0]) cells[a[10:1]][15:8] = v[7:0];
			else cells[a[10:1]][7:0] = v[7:0];
		endfunction

		function void decode();
			logic [16:0] op;
			logic [1:0]  sub;
			op        = cmd_shift >> addr_len;
			sub       = cmd_shift[addr_len-1 -: 2];
			phase     = mwe_pkg::PH_IDLE;
			word_addr = cmd_shift[10:0] & word_mask;
			case (op)
				mwe_pkg::OP_ERASE: if (!locked) commit(word_addr, 17'h0FFFF);
				mwe_pkg::OP_READ: begin
					read_shift = fetch(word_addr);
					out_level  = 1'b0;
					phase      = mwe_pkg::PH_WAIT;
				end
				mwe_pkg::OP_WRITE: begin
					cmd_shift = 17'd1;
					phase     = mwe_pkg::PH_DATA;
				end
				mwe_pkg::OP_EXT: begin
					if (sub == mwe_pkg::SUB_EWDS) locked = 1'b1;
					else if (sub == mwe_pkg::SUB_EWEN) locked = 1'b0;
				end
				default: ;
			endcase
		endfunction

		function void clock_rise(logic cs);
			logic driven;
			logic di;
			driven     = dir_latch[4];
			di         = driven & level_latch[4];
			out_level  = |(read_shift & done_bit[16:1]);
			read_shift = read_shift << 1;
			if (!cs) phase = mwe_pkg::PH_IDLE;
			case (phase)
				mwe_pkg::PH_IDLE: begin
					cmd_shift = '0;
					if (cs && di) begin
						out_level = 1'b0;
						phase     = mwe_pkg::PH_START;
						bits_left = 4'(cmd_len - 1);
					end else if (cs && !driven) begin
						// DI floating with chip select high: ready poll
						phase      = mwe_pkg::PH_BUSY;
						read_shift = '0;
						out_level  = 1'b0;
						busy_ticks = '0;
					end
				end
				mwe_pkg::PH_START: begin
					cmd_shift = {cmd_shift[15:0], di};
					bits_left = bits_left - 4'd1;
					if (bits_left == 4'd0 && real_chip) decode();
				end
				mwe_pkg::PH_DATA: begin
					cmd_shift = {cmd_shift[15:0], di};
					if (|(cmd_shift & done_bit)) begin
						if (!locked) commit(word_addr, cmd_shift);
						busy_ticks = '0;
						read_shift = '0;
						out_level  = 1'b0;
						phase      = mwe_pkg::PH_WAIT;
					end
				end
				default: ;
			endcase
		endfunction

		// one accepted item in, one predicted DO level queued
		function void note_input(logic [1:0] f, logic [7:0] cnt, logic [7:0] dir,
				logic [7:0] lvl);
			logic rise;
			case (f)
				mwe_pkg::FN_STROBE: begin
					rise     = cnt[1] && !last_clk;
					last_clk = cnt[1];
					if (rise) clock_rise(cnt[7]);
				end
				mwe_pkg::FN_LATCH: begin
					dir_latch   = dir;
					level_latch = lvl;
				end
				mwe_pkg::FN_POLL: begin
					if (phase == mwe_pkg::PH_BUSY || phase == mwe_pkg::PH_IDLE) begin
						if (busy_ticks < 2'd2) begin
							busy_ticks = busy_ticks + 2'd1;
							read_shift = '0;
							out_level  = 1'b0;
						end else begin
							read_shift = 16'hFFFF;
							out_level  = 1'b1;
							phase      = mwe_pkg::PH_WAIT;
						end
					end
				end
				default: ;
			endcase
			do_levels_due.push_back(out_level);
		endfunction

		task report(string msg);
			if (errors < 100) $display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(logic level);
			logic want;
			if (do_levels_due.size() == 0) begin
				report($sformatf("data_out=%0b with no item outstanding", level));
				return;
			end
			want = do_levels_due.pop_front();
			if (level !== want)
				report($sformatf("result %0d: data_out=%0b, predicted %0b", checked, level, want));
			checked++;
		endtask
	endclass

	// ------------------------------------------------------------------------
	// signals; every block input is known from time zero
	// ------------------------------------------------------------------------
	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_ready;
	logic [1:0] func         = '0;
	logic [7:0] count_value  = '0;
	logic [7:0] io_direction = '0;
	logic [7:0] io_level     = '0;
	logic       out_valid;
	logic       out_ready    = 1'b0;
	logic       data_out;
	logic       cfg_we       = 1'b0;
	logic       cfg_index    = 1'b0;
	logic [2:0] cfg_data     = '0;

	do_scoreboard sb;
	int idle_pct;      // sender gap chance, percent
	int stall_pct;     // receiver stall chance, percent
	int hold_asks;     // bumped by the stimulus to request a long hold-off
	int hold_served;
	int items_sent;
	int quiet = 0;

	always #5 clk = ~clk;

	microwire_eeprom_93cx6_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.count_value  (count_value),
		.io_direction (io_direction),
		.io_level     (io_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_out     (data_out),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------------
	// receiver: random stalls, or a long hold-off counted here when asked
	// ------------------------------------------------------------------------
	initial begin
		hold_served = 0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_asks) begin
				hold_served = hold_asks;
				out_ready <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// result checker: sample at the rising edge, before the core updates
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(data_out);
	end

	// watchdog: ends a run in which no item moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ------------------------------------------------------------------------
	// drivers: change inputs on the falling edge, detect acceptance on the rising
	// ------------------------------------------------------------------------

	// Offers one item; valid stays high after acceptance so back-to-back items
	// never drop it. A gap lowers it at a later falling edge.
	task automatic send_item(input logic [1:0] f, input logic [7:0] cnt,
			input logic [7:0] dir, input logic [7:0] lvl);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		count_value  <= cnt;
		io_direction <= dir;
		io_level     <= lvl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(f, cnt, dir, lvl);
		items_sent++;
	endtask

	// counter strobe: bit 7 chip select, bit 1 serial clock, the rest noise
	task automatic strobe(input logic cs, input logic sk);
		logic [7:0] cnt;
		cnt    = 8'($urandom);
		cnt[7] = cs;
		cnt[1] = sk;
		send_item(mwe_pkg::FN_STROBE, cnt, 8'($urandom), 8'($urandom));
	endtask

	// latch update: bit 4 of direction drives DI, bit 4 of level is its value
	task automatic set_di(input logic drive, input logic di);
		logic [7:0] dir;
		logic [7:0] lvl;
		dir    = 8'($urandom);
		lvl    = 8'($urandom);
		dir[4] = drive;
		lvl[4] = di;
		send_item(mwe_pkg::FN_LATCH, 8'($urandom), dir, lvl);
	endtask

	// one low-high clock pair, giving one rising edge at chip select cs
	task automatic clock_bit(input logic cs);
		strobe(cs, 1'b0);
		strobe(cs, 1'b1);
	endtask

	task automatic shift_bit(input logic b);
		set_di(1'b1, b);
		clock_bit(1'b1);
	endtask

	task automatic write_reg(input logic idx, input logic [2:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.do_levels_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// A bit-banged command for the current geometry: start bit, opcode and
	// address MSB first, then read-out clocks or write data, sometimes a
	// ready poll. A cut command stops part way, with chip select dropped or
	// left high (the latter lets a kind change land mid-command).
	task automatic run_command(input cmd_shape_t shape);
		int abits, len, cut, pick, op, sub, addr, i;
		logic [16:0] word;
		logic [15:0] wdata;
		abits = sb.real_chip ? sb.addr_len : 6;
		len   = abits + 3;
		pick  = $urandom_range(99);
		if (pick < 30) op = mwe_pkg::OP_READ;
		else if (pick < 60) op = mwe_pkg::OP_WRITE;
		else if (pick < 70) op = mwe_pkg::OP_ERASE;
		else op = mwe_pkg::OP_EXT;
		pick = $urandom_range(99);
		if (pick < 55) sub = mwe_pkg::SUB_EWEN;
		else if (pick < 75) sub = mwe_pkg::SUB_EWDS;
		else if (pick < 88) sub = SUB_WRAL;
		else sub = SUB_ERAL;

		// bias toward a few low addresses so reads find earlier writes
		pick = $urandom_range(9);
		if (pick < 5) addr = $urandom_range(3);
		else if (pick == 5) addr = -1;
		else addr = $urandom;
		addr = addr & ((1 << abits) - 1);
		if (op == mwe_pkg::OP_EXT) addr = (addr & ~(3 << (abits - 2))) | (sub << (abits - 2));
		word = 17'((1 << (abits + 2)) | (op << abits) | addr);

		cut = (shape == CMD_FULL) ? len : $urandom_range(len - 1, 1);
		clock_bit(1'b0);                  // deselect edge: back to idle
		for (i = len - 1; i >= len - cut; i--) shift_bit(word[i]);
		if (shape == CMD_CUT_DROP) clock_bit(1'b0);
		if (shape != CMD_FULL) return;

		if (op == mwe_pkg::OP_READ) begin
			repeat (sb.byte_acc ? 9 : 17) clock_bit(1'b1);
		end else if (op == mwe_pkg::OP_WRITE) begin
			wdata = 16'($urandom);
			for (i = sb.byte_acc ? 7 : 15; i >= 0; i--) shift_bit(wdata[i]);
		end

		if ($urandom_range(2) == 0) begin
			// ready poll: float DI, select, then tick until ready
			set_di(1'b0, 1'($urandom));
			clock_bit(1'b0);
			clock_bit(1'b1);
			repeat (3) send_item(mwe_pkg::FN_POLL, 8'($urandom), 8'($urandom), 8'($urandom));
			repeat ($urandom_range(3, 1)) clock_bit(1'b1);
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [2:0] val;
		int pick;
		int target;

		sb         = new();
		idle_pct   = 0;
		stall_pct  = 0;
		hold_asks  = 0;
		items_sent = 0;

		// reset released on a falling edge; the clear pass
		// that follows just shows up as in_ready held low
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(mwe_pkg::REG_CHIP_KIND, mwe_pkg::KIND_C46);
		write_reg(mwe_pkg::REG_BYTE_ACCESS, 3'b001);

		// Directed: field extremes, all four item kinds, a ready poll from a
		// floating DI, ready shifted out, start from a driven DI, DI forced
		// low when not driven, and a poll tick while idle.
		send_item(FN_SPARE,           8'hFF, 8'hFF, 8'hFF);
		send_item(mwe_pkg::FN_LATCH,  8'h00, 8'h00, 8'h00);
		send_item(mwe_pkg::FN_STROBE, 8'h00, 8'hFF, 8'hFF);
		send_item(mwe_pkg::FN_STROBE, 8'h82, 8'h00, 8'h00);   // select with DI floating
		repeat (3) send_item(mwe_pkg::FN_POLL, 8'hFF, 8'hFF, 8'hFF);
		send_item(mwe_pkg::FN_STROBE, 8'h80, 8'h00, 8'h00);
		send_item(mwe_pkg::FN_STROBE, 8'hFF, 8'h00, 8'h00);   // ones shift out
		send_item(mwe_pkg::FN_STROBE, 8'h7D, 8'h00, 8'h00);
		send_item(mwe_pkg::FN_STROBE, 8'h7F, 8'h00, 8'h00);   // deselect edge
		send_item(mwe_pkg::FN_LATCH,  8'h00, 8'hFF, 8'hFF);
		send_item(mwe_pkg::FN_STROBE, 8'h80, 8'h00, 8'h00);
		send_item(mwe_pkg::FN_STROBE, 8'h82, 8'h00, 8'h00);   // start bit
		send_item(mwe_pkg::FN_LATCH,  8'hFF, 8'hFF, 8'hEF);
		send_item(mwe_pkg::FN_STROBE, 8'h80, 8'h00, 8'h00);
		send_item(mwe_pkg::FN_STROBE, 8'h82, 8'h00, 8'h00);
		send_item(mwe_pkg::FN_LATCH,  8'hFF, 8'hEF, 8'hFF);   // level high but not driven
		send_item(mwe_pkg::FN_STROBE, 8'h80, 8'h00, 8'h00);
		send_item(mwe_pkg::FN_STROBE, 8'h82, 8'h00, 8'h00);
		send_item(mwe_pkg::FN_STROBE, 8'h00, 8'h00, 8'h00);
		send_item(mwe_pkg::FN_STROBE, 8'h02, 8'h00, 8'h00);
		send_item(mwe_pkg::FN_POLL,   8'h00, 8'h00, 8'h00);   // tick while idle
		send_item(FN_SPARE,           8'h00, 8'h00, 8'h00);

		// Random phases, one chip setting each. Idle modes rotate: none,
		// sender gaps, receiver stalls, both.
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			drain();
			write_reg(mwe_pkg::REG_CHIP_KIND, KIND_SEQ[p]);
			val    = 3'($urandom);
			val[0] = BYTE_SEQ[p];
			write_reg(mwe_pkg::REG_BYTE_ACCESS, val);

			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 63; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 63; end
				default: begin idle_pct = 34; stall_pct = 34; end
			endcase
			// once: the receiver holds off while items keep coming
			if (p == 2) hold_asks++;

			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					run_command(CMD_FULL);
				end else if (pick < 87) begin
					run_command(CMD_CUT_DROP);
				end else begin
					repeat ($urandom_range(6, 1))
						send_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				end
				// a mid-phase wait for every result, guarded by idle_pct == 0, which phase 5 never has
				if (p == 5 && items_sent >= target - PHASE_ITEMS / 2 && idle_pct == 0) begin
					drain();
					idle_pct = 1;
				end
			end
			// leave a command partly sent so the next setting lands mid-command
			if (p % 2 == 1) run_command(CMD_CUT_HOLD);
		end

		drain();
		if (sb.errors == 0 && sb.do_levels_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
